// File: sv/descriptor_slot_table_core_assert.svh
// ----------------------------------------------------------------------------
// Descriptor slot table assertion macros
// Shared property forms used by the descriptor slot table RTL.
// ----------------------------------------------------------------------------
`ifndef DESCRIPTOR_SLOT_TABLE_CORE_ASSERT_SVH
`define DESCRIPTOR_SLOT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and off while arst_n is low.
`define DST_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and off while arst_n is low.
`define DST_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/dst_pkg.sv
// ----------------------------------------------------------------------------
// Descriptor slot table package
// Field widths, command and status codes, and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dst_pkg;

	// Fixed field widths of the stream payloads.
	localparam int HANDLE_WIDTH   = 16;
	localparam int FLAGS_WIDTH    = 8;
	localparam int SLOT_WIDTH     = 9;
	localparam int RSLOT_WIDTH    = 8;
	localparam int IN_DATA_WIDTH  = 48;
	localparam int OUT_DATA_WIDTH = 40;

	// Close-on-exec bit position inside the flags word.
	localparam int CLOEXEC_BIT = 0;

	typedef enum logic [2:0] {
		CMD_LOOKUP  = 3'd0,
		CMD_READ    = 3'd1,
		CMD_WRITE   = 3'd2,
		CMD_CLOSE   = 3'd3,
		CMD_INSTALL = 3'd4,
		CMD_COPY    = 3'd5,
		CMD_FIND    = 3'd6,
		CMD_SWEEP   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_BADF  = 2'd1,
		ST_INVAL = 2'd2,
		ST_MFILE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SWEEP_RD,
		S_SWEEP_CK
	} state_t;

endpackage

`default_nettype wire

// File: sv/dst_ram.sv
// ----------------------------------------------------------------------------
// Descriptor slot table RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module dst_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port, data registered; a read in the cycle of a write sees the old word.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// File: sv/descriptor_slot_table_core.sv
// ----------------------------------------------------------------------------
// Descriptor slot table core
// Fixed table of descriptor slots with lookup, flag access, close, install,
// copy, lowest-free search and close-on-exec sweep, one command per transaction.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Width  Contents (lowest bit first)
// s_axis    in         48     command, slot, dest_slot, handle, flag_value
// m_axis    out        40     status, result_slot, handle_out, flags_out
//
// Lookup, read, write, close, copy and install at a given slot load the result
// register from the execute state that follows acceptance, then return to idle.
// Find free and install at the lowest free slot step one slot per cycle through
// the shared scan counter in the scan state, which loads the result register.
// Sweep reads the flags RAM once per slot, in a read state and a check state per slot.
// Reset clears valid and flags-written bits at once; no clearing pass is needed.
// The input is ready only in idle; a stalled output holds the final step.
`default_nettype none

module descriptor_slot_table_core #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// command[2:0], slot[11:3], dest_slot[20:12], handle[36:21],
	// flag_value[44:37], zero pad[47:45]
	input  logic [dst_pkg::IN_DATA_WIDTH-1:0]    s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// status[1:0], result_slot[9:2], handle_out[25:10], flags_out[33:26],
	// zero pad[39:34]
	output logic [dst_pkg::OUT_DATA_WIDTH-1:0]   m_axis_tdata
);

	import dst_pkg::*;

	`include "descriptor_slot_table_core_assert.svh"

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam logic [SLOT_WIDTH-1:0] SLOT_DEPTH = SLOT_WIDTH'(TABLE_DEPTH);
	localparam logic [SLOT_WIDTH-1:0] SLOT_PICK  = '1;
	localparam logic [IDX_W-1:0]      LAST_IDX   = IDX_W'(TABLE_DEPTH - 1);
	localparam int OUT_PAD = OUT_DATA_WIDTH - 2 - RSLOT_WIDTH - HANDLE_WIDTH - FLAGS_WIDTH;

	// Sequencer and latched command.
	state_t                  state_q, state_d;
	cmd_t                    cmd_q;
	logic [SLOT_WIDTH-1:0]   slot_q, dest_q;
	logic [HANDLE_WIDTH-1:0] handle_q;
	logic [FLAGS_WIDTH-1:0]  flag_q;
	logic [IDX_W-1:0]        idx_q;

	// Per-slot flip-flop state.
	logic [TABLE_DEPTH-1:0]  slot_valid_q;
	logic [TABLE_DEPTH-1:0]  flags_wr_q;

	// Output register.
	logic                      out_valid_q;
	logic [OUT_DATA_WIDTH-1:0] out_data_q;

	// Input fields.
	logic [SLOT_WIDTH-1:0]   in_slot;
	logic                    accept;
	logic                    out_free;
	logic                    slot_ok, dest_ok;
	logic [IDX_W-1:0]        slot_idx, dest_idx;
	logic                    scan_last;

	// RAM ports.
	logic [IDX_W-1:0]        rd_addr;
	logic [HANDLE_WIDTH-1:0] rd_handle;
	logic [FLAGS_WIDTH-1:0]  rd_flags;
	logic                    wr_en_h, wr_en_f;
	logic [HANDLE_WIDTH-1:0] wr_handle;
	logic [FLAGS_WIDTH-1:0]  wr_flags;

	// Entry update controls; every write of one cycle targets ent_idx.
	logic [IDX_W-1:0]        ent_idx;
	logic                    vld_we, vld_val, fw_we, fw_val;
	logic                    idx_ld, idx_inc;
	logic [IDX_W-1:0]        idx_ld_val;

	// Result of the finishing step.
	logic                    res_load;
	status_t                 res_status;
	logic [RSLOT_WIDTH-1:0]  res_slot;
	logic [HANDLE_WIDTH-1:0] res_handle;
	logic [FLAGS_WIDTH-1:0]  res_flags;

	// Handshake and decode of the latched fields.
	assign in_slot       = s_axis_tdata[11:3];
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign slot_ok       = !slot_q[SLOT_WIDTH-1] && (slot_q < SLOT_DEPTH);
	assign dest_ok       = !dest_q[SLOT_WIDTH-1] && (dest_q < SLOT_DEPTH);
	assign slot_idx      = slot_q[IDX_W-1:0];
	assign dest_idx      = dest_q[IDX_W-1:0];
	assign scan_last     = (idx_q == LAST_IDX);

	// Read address: the incoming slot in idle so data is ready in execute.
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = in_slot[IDX_W-1:0];
			S_EXEC:  rd_addr = slot_idx;
			default: rd_addr = idx_q;
		endcase
	end

	dst_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (HANDLE_WIDTH)
	) u_handle_ram (
		.clk     (clk),
		.wr_en   (wr_en_h),
		.wr_addr (ent_idx),
		.wr_data (wr_handle),
		.rd_addr (rd_addr),
		.rd_data (rd_handle)
	);

	dst_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (FLAGS_WIDTH)
	) u_flags_ram (
		.clk     (clk),
		.wr_en   (wr_en_f),
		.wr_addr (ent_idx),
		.wr_data (wr_flags),
		.rd_addr (rd_addr),
		.rd_data (rd_flags)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_INSTALL: begin
						if (slot_q == SLOT_PICK) state_d = S_SCAN;
						else if (out_free)       state_d = S_IDLE;
					end
					CMD_FIND: begin
						if (slot_ok)       state_d = S_SCAN;
						else if (out_free) state_d = S_IDLE;
					end
					CMD_SWEEP: state_d = S_SWEEP_RD;
					default: begin
						if (out_free) state_d = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if ((!slot_valid_q[idx_q] || scan_last) && out_free) state_d = S_IDLE;
			end
			S_SWEEP_RD: state_d = S_SWEEP_CK;
			S_SWEEP_CK: begin
				if (!scan_last)    state_d = S_SWEEP_RD;
				else if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Output logic: table updates, scan counter control and result.
	always_comb begin
		res_load   = 1'b0;
		res_status = ST_OK;
		res_slot   = '0;
		res_handle = '0;
		res_flags  = '0;
		wr_en_h    = 1'b0;
		wr_en_f    = 1'b0;
		wr_handle  = handle_q;
		wr_flags   = flag_q;
		ent_idx    = slot_idx;
		vld_we     = 1'b0;
		vld_val    = 1'b0;
		fw_we      = 1'b0;
		fw_val     = 1'b0;
		idx_ld     = 1'b0;
		idx_ld_val = '0;
		idx_inc    = 1'b0;
		case (state_q)
			S_EXEC: begin
				case (cmd_q)
					CMD_LOOKUP: begin
						res_load = out_free;
						if (slot_ok && slot_valid_q[slot_idx]) res_handle = rd_handle;
						else                                    res_status = ST_BADF;
					end
					CMD_READ: begin
						res_load = out_free;
						if (slot_ok) begin
							if (flags_wr_q[slot_idx]) res_flags = rd_flags;
						end else begin
							res_status = ST_BADF;
						end
					end
					CMD_WRITE: begin
						res_load = out_free;
						if (slot_ok) begin
							wr_en_f = out_free;
							fw_we   = out_free;
							fw_val  = 1'b1;
						end else begin
							res_status = ST_BADF;
						end
					end
					CMD_CLOSE: begin
						res_load = out_free;
						if (slot_ok && slot_valid_q[slot_idx]) begin
							vld_we = out_free;
						end else begin
							res_status = ST_BADF;
						end
					end
					CMD_INSTALL: begin
						if (slot_q == SLOT_PICK) begin
							idx_ld = 1'b1;
						end else begin
							res_load = out_free;
							if (slot_ok) begin
								// Flags read as zero once the flags-written bit drops.
								wr_en_h  = out_free;
								vld_we   = out_free;
								vld_val  = 1'b1;
								fw_we    = out_free;
								res_slot = RSLOT_WIDTH'(slot_idx);
							end else begin
								res_status = ST_BADF;
							end
						end
					end
					CMD_COPY: begin
						res_load = out_free;
						ent_idx  = dest_idx;
						if (slot_ok && dest_ok && slot_valid_q[slot_idx]) begin
							wr_en_h   = out_free;
							wr_en_f   = out_free;
							wr_handle = rd_handle;
							wr_flags  = rd_flags;
							vld_we    = out_free;
							vld_val   = 1'b1;
							fw_we     = out_free;
							fw_val    = flags_wr_q[slot_idx];
						end else begin
							res_status = ST_BADF;
						end
					end
					CMD_FIND: begin
						if (slot_q[SLOT_WIDTH-1]) begin
							res_load   = out_free;
							res_status = ST_INVAL;
						end else if (!slot_ok) begin
							res_load   = out_free;
							res_status = ST_MFILE;
						end else begin
							idx_ld     = 1'b1;
							idx_ld_val = slot_idx;
						end
					end
					default: begin
						idx_ld = 1'b1;
					end
				endcase
			end
			S_SCAN: begin
				ent_idx = idx_q;
				if (!slot_valid_q[idx_q]) begin
					res_load = out_free;
					res_slot = RSLOT_WIDTH'(idx_q);
					if (cmd_q == CMD_INSTALL) begin
						wr_en_h = out_free;
						vld_we  = out_free;
						vld_val = 1'b1;
						fw_we   = out_free;
					end
				end else if (scan_last) begin
					res_load   = out_free;
					res_status = ST_MFILE;
				end else begin
					idx_inc = 1'b1;
				end
			end
			S_SWEEP_CK: begin
				// Close a valid slot whose stored flags carry close-on-exec.
				ent_idx = idx_q;
				if (slot_valid_q[idx_q] && flags_wr_q[idx_q] && rd_flags[CLOEXEC_BIT]) begin
					vld_we = 1'b1;
				end
				if (scan_last) res_load = out_free;
				else           idx_inc  = 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// Sequencer state and scan counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (idx_ld)       idx_q <= idx_ld_val;
			else if (idx_inc) idx_q <= idx_q + 1'b1;
		end
	end

	// Command capture on an accepted transaction.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q    <= cmd_t'(s_axis_tdata[2:0]);
			slot_q   <= in_slot;
			dest_q   <= s_axis_tdata[20:12];
			handle_q <= s_axis_tdata[36:21];
			flag_q   <= s_axis_tdata[44:37];
		end
	end

	// Valid and flags-written bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			flags_wr_q   <= '0;
		end else begin
			if (vld_we) slot_valid_q[ent_idx] <= vld_val;
			if (fw_we)  flags_wr_q[ent_idx]   <= fw_val;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= {{OUT_PAD{1'b0}}, res_flags, res_handle, res_slot, res_status};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Assertions.
	`DST_ASSERT_NXT(a_accept_exec, accept, state_q == S_EXEC, "accepted transaction did not enter execute")
	`DST_ASSERT_IMP(a_out_from_seq, $rose(m_axis_tvalid), $past(res_load), "result appeared without a finishing step")
	`DST_ASSERT_NXT(a_install_valid, res_load && (cmd_q == CMD_INSTALL) && (res_status == ST_OK), slot_valid_q[$past(ent_idx)], "installed slot not marked valid")
	`DST_ASSERT_IMP(a_scan_cmd, state_q == S_SCAN, (cmd_q == CMD_INSTALL) || (cmd_q == CMD_FIND), "free-slot scan running for a wrong command")

endmodule

`default_nettype wire

// File: test/descriptor_slot_table_core_tb.sv
// ----------------------------------------------------------------------------
// Descriptor slot table core testbench
// Drives command transactions into the slot table and checks every response
// against a behavioral copy of the table kept in the bench. A directed pass
// covers field extremes and corner cases. A full-table pass follows, then random
// traffic with and without idle cycles, with a long output stall part way through.
// ----------------------------------------------------------------------------
`default_nettype none

module descriptor_slot_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dst_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SWEEP_CYCLES = 2 * TABLE_DEPTH + 8;

	// One command transaction as it travels on the input stream.
	typedef struct packed {
		logic [7:0]        flag_value;
		logic [15:0]       handle;
		logic signed [8:0] dest_slot;
		logic signed [8:0] slot;
		cmd_t              cmd;
	} cmd_req_t;

	// One response transaction.
	typedef struct packed {
		status_t     status;
		logic [7:0]  result_slot;
		logic [15:0] handle_out;
		logic [7:0]  flags_out;
	} reply_t;

	logic                      clk;
	logic                      arst_n;
	logic                      s_axis_tvalid;
	logic                      s_axis_tready;
	logic [IN_DATA_WIDTH-1:0]  s_axis_tdata;
	logic                      m_axis_tvalid;
	logic                      m_axis_tready;
	logic [OUT_DATA_WIDTH-1:0] m_axis_tdata;

	// Bench copy of the table contents.
	bit          tbl_open [TABLE_DEPTH];
	logic [15:0] tbl_handle [TABLE_DEPTH];
	logic [7:0]  tbl_flags [TABLE_DEPTH];

	reply_t pending_replies [$];

	bit idle_on;
	int hold_left;
	int cycles;
	int errors;
	int replies_checked;
	int cmd_count [8];
	int status_count [4];

	descriptor_slot_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run limit; a hung block ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Table model
	// ------------------------------------------------------------------------

	function automatic bit in_range(int s);
		return s >= 0 && s < TABLE_DEPTH;
	endfunction

	// Lowest closed slot at or above start, or -1 when there is none.
	function automatic int first_free_from(int start);
		int i;
		for (i = start; i < TABLE_DEPTH; i++)
			if (!tbl_open[i])
				return i;
		return -1;
	endfunction

	// Applies one command to the bench table and returns the response it gives.
	function automatic reply_t apply_cmd(cmd_req_t r);
		reply_t rep;
		int     s;
		int     d;
		int     i;
		bit     full;
		rep = '{status: ST_OK, default: '0};
		s = $signed(r.slot);
		d = $signed(r.dest_slot);
		full = 1'b0;
		case (r.cmd)
			CMD_LOOKUP: begin
				if (in_range(s) && tbl_open[s])
					rep.handle_out = tbl_handle[s];
				else
					rep.status = ST_BADF;
			end
			CMD_READ: begin
				if (in_range(s))
					rep.flags_out = tbl_flags[s];
				else
					rep.status = ST_BADF;
			end
			CMD_WRITE: begin
				if (in_range(s))
					tbl_flags[s] = r.flag_value;
				else
					rep.status = ST_BADF;
			end
			CMD_CLOSE: begin
				if (in_range(s) && tbl_open[s])
					tbl_open[s] = 1'b0;
				else
					rep.status = ST_BADF;
			end
			CMD_INSTALL: begin
				if (s == -1) begin
					s = first_free_from(0);
					full = (s < 0);
				end
				if (full) begin
					rep.status = ST_MFILE;
				end else if (!in_range(s)) begin
					rep.status = ST_BADF;
				end else begin
					tbl_open[s] = 1'b1;
					tbl_handle[s] = r.handle;
					tbl_flags[s] = '0;
					rep.result_slot = 8'(s);
				end
			end
			CMD_COPY: begin
				if (!in_range(s) || !in_range(d) || !tbl_open[s]) begin
					rep.status = ST_BADF;
				end else begin
					tbl_open[d] = tbl_open[s];
					tbl_handle[d] = tbl_handle[s];
					tbl_flags[d] = tbl_flags[s];
				end
			end
			CMD_FIND: begin
				if (s < 0) begin
					rep.status = ST_INVAL;
				end else begin
					i = first_free_from(s);
					if (i < 0)
						rep.status = ST_MFILE;
					else
						rep.result_slot = 8'(i);
				end
			end
			default: begin
				for (i = 0; i < TABLE_DEPTH; i++)
					if (tbl_open[i] && tbl_flags[i][CLOEXEC_BIT])
						tbl_open[i] = 1'b0;
			end
		endcase
		return rep;
	endfunction

	// ------------------------------------------------------------------------
	// Stream driver and response checker
	// ------------------------------------------------------------------------

	// Offers one command, waits for its transaction and records the response
	// it must produce. Valid stays high afterward for back-to-back commands.
	task automatic send_cmd(cmd_t cmd, int slot, int dest_slot, int handle, int flag_value);
		cmd_req_t r;
		int       gap;
		r.cmd = cmd;
		r.slot = 9'(slot);
		r.dest_slot = 9'(dest_slot);
		r.handle = 16'(handle);
		r.flag_value = 8'(flag_value);
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, r};
		do @(posedge clk); while (!s_axis_tready);
		pending_replies.push_back(apply_cmd(r));
		cmd_count[int'(cmd)]++;
	endtask

	// Receiver readiness: random stall bursts, plus a long counted hold-off
	// whenever a test requests one.
	initial begin
		int stall_left;
		stall_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 8) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each response transaction with the oldest expected one.
	always @(posedge clk) begin
		reply_t got;
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.status = status_t'(m_axis_tdata[1:0]);
			got.result_slot = m_axis_tdata[9:2];
			got.handle_out = m_axis_tdata[25:10];
			got.flags_out = m_axis_tdata[33:26];
			status_count[got.status]++;
			if (pending_replies.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected response: st=%0d slot=%0d h=%h f=%h",
						got.status, got.result_slot, got.handle_out, got.flags_out);
			end else begin
				want = pending_replies.pop_front();
				replies_checked++;
				if (got.status !== want.status || got.result_slot !== want.result_slot ||
						got.handle_out !== want.handle_out ||
						got.flags_out !== want.flags_out) begin
					errors++;
					if (errors <= 10)
						$display("response %0d: expected st=%0d slot=%0d h=%h f=%h, got st=%0d slot=%0d h=%h f=%h",
							replies_checked, want.status, want.result_slot, want.handle_out,
							want.flags_out, got.status, got.result_slot, got.handle_out,
							got.flags_out);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Slot number for random commands: mostly in the table, sometimes the
	// negative marker or past the end; optionally biased toward open slots.
	function automatic int pick_slot(bit prefer_open);
		int r;
		int i;
		int open_list [$];
		r = $urandom_range(0, 99);
		if (r < 6)
			return -1;
		if (r < 12)
			return $urandom_range(TABLE_DEPTH, 255);
		if (prefer_open && r < 60) begin
			for (i = 0; i < TABLE_DEPTH; i++)
				if (tbl_open[i])
					open_list.push_back(i);
			if (open_list.size() > 0)
				return open_list[$urandom_range(0, open_list.size() - 1)];
		end
		return $urandom_range(0, TABLE_DEPTH - 1);
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Corner cases: field extremes, every command, every error status.
	task automatic test_directed();
		send_cmd(CMD_READ, 0, 0, 0, 0);
		send_cmd(CMD_LOOKUP, 0, 0, 0, 0);
		send_cmd(CMD_CLOSE, 0, 0, 0, 0);
		send_cmd(CMD_INSTALL, -1, 0, 16'hFFFF, 8'hFF);
		send_cmd(CMD_INSTALL, TABLE_DEPTH - 1, 0, 0, 0);
		send_cmd(CMD_INSTALL, 255, 0, 16'h1234, 0);
		send_cmd(CMD_LOOKUP, 0, 0, 0, 0);
		send_cmd(CMD_WRITE, TABLE_DEPTH - 1, 0, 0, 8'hFF);
		send_cmd(CMD_READ, TABLE_DEPTH - 1, 0, 0, 0);
		// Installing over an open slot clears its flags.
		send_cmd(CMD_INSTALL, TABLE_DEPTH - 1, -1, 16'hA5A5, 0);
		send_cmd(CMD_READ, TABLE_DEPTH - 1, 0, 0, 0);
		send_cmd(CMD_COPY, 0, 0, 0, 0);
		send_cmd(CMD_COPY, 0, 5, 0, 0);
		send_cmd(CMD_COPY, 10, 11, 0, 0);
		send_cmd(CMD_COPY, 0, -1, 0, 0);
		send_cmd(CMD_COPY, 0, 255, 0, 0);
		send_cmd(CMD_LOOKUP, TABLE_DEPTH, 0, 0, 0);
		send_cmd(CMD_READ, -1, 0, 0, 0);
		send_cmd(CMD_WRITE, 255, 0, 0, 8'h01);
		send_cmd(CMD_FIND, -1, 0, 0, 0);
		send_cmd(CMD_FIND, TABLE_DEPTH, 0, 0, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0);
		// Closing keeps the flags; the sweep then drops the close-on-exec slot.
		send_cmd(CMD_WRITE, 0, 0, 0, 8'h80);
		send_cmd(CMD_CLOSE, 0, 0, 0, 0);
		send_cmd(CMD_READ, 0, 0, 0, 0);
		send_cmd(CMD_WRITE, 5, 0, 0, 8'h01);
		send_cmd(CMD_SWEEP, 0, 0, 0, 0);
		send_cmd(CMD_LOOKUP, 5, 0, 0, 0);
	endtask

	// Fill every slot, hit the too-many-open paths, then sweep part of it away.
	task automatic test_full_table();
		int i;
		while (first_free_from(0) >= 0)
			send_cmd(CMD_INSTALL, -1, 0, $urandom_range(0, 16'hFFFF), 0);
		send_cmd(CMD_INSTALL, -1, 0, 16'h0F0F, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0);
		send_cmd(CMD_FIND, TABLE_DEPTH - 1, 0, 0, 0);
		for (i = 0; i < 8; i++)
			send_cmd(CMD_WRITE, $urandom_range(0, TABLE_DEPTH - 1), 0, 0,
				$urandom_range(0, 255) | 1);
		send_cmd(CMD_SWEEP, 0, 0, 0, 0);
		send_cmd(CMD_FIND, 0, 0, 0, 0);
	endtask

	// Random commands, mostly aimed at open slots so the table stays busy.
	task automatic test_random(int count);
		int n;
		int r;
		int s;
		for (n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				send_cmd(CMD_LOOKUP, pick_slot(1), 0, 0, 0);
			else if (r < 27)
				send_cmd(CMD_READ, pick_slot(0), 0, 0, 0);
			else if (r < 42)
				send_cmd(CMD_WRITE, pick_slot(1), 0, 0, $urandom_range(0, 255));
			else if (r < 54)
				send_cmd(CMD_CLOSE, pick_slot(1), 0, 0, 0);
			else if (r < 72)
				send_cmd(CMD_INSTALL, ($urandom_range(0, 1) != 0) ? -1 : pick_slot(0), 0,
					$urandom_range(0, 16'hFFFF), 0);
			else if (r < 84) begin
				s = pick_slot(1);
				send_cmd(CMD_COPY, s, ($urandom_range(0, 9) == 0) ? s : pick_slot(0), 0, 0);
			end else if (r < 96)
				send_cmd(CMD_FIND, ($urandom_range(0, 3) == 0) ? pick_slot(0) :
					$urandom_range(0, 15), 0, 0, 0);
			else
				send_cmd(CMD_SWEEP, $urandom_range(0, 255), $urandom_range(0, 255),
					$urandom_range(0, 16'hFFFF), $urandom_range(0, 255));
		end
	endtask

	// Long receiver hold-off while commands keep coming, so the input stalls.
	task automatic test_backpressure();
		@(posedge clk);
		hold_left = 300;
		test_random(20);
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		idle_on = 1'b1;
		hold_left = 0;
		cycles = 0;
		errors = 0;
		replies_checked = 0;
		foreach (tbl_open[i]) begin
			tbl_open[i] = 1'b0;
			tbl_handle[i] = '0;
			tbl_flags[i] = '0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_full_table();
		test_random(550);
		test_backpressure();
		test_random(650);
		// Last stretch streams with no idle cycles on either side.
		idle_on = 1'b0;
		test_random(150);

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (SWEEP_CYCLES) @(posedge clk);
		errors += pending_replies.size();

		$display("Covered %0d commands (%0d installs, %0d copies, %0d sweeps), %0d responses checked.",
			cmd_count.sum(), cmd_count[CMD_INSTALL], cmd_count[CMD_COPY],
			cmd_count[CMD_SWEEP], replies_checked);
		$display("Statuses seen: ok %0d, bad descriptor %0d, invalid %0d, too many open %0d; %0d errors.",
			status_count[ST_OK], status_count[ST_BADF], status_count[ST_INVAL],
			status_count[ST_MFILE], errors);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+sv
sv/dst_pkg.sv
sv/dst_ram.sv
sv/descriptor_slot_table_core.sv
test/descriptor_slot_table_core_tb.sv
